/* rtl/bps_pkg.sv */
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the buzzer pattern sequencer: beat formats,
// operation and mode codes, pattern timing.
// ----------------------------------------------------------------------------
package bps_pkg;

  // operation codes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_SET_MODE = 2'd1;
  localparam logic [1:0] OP_BEEP     = 2'd2;

  // background modes
  localparam logic [1:0] MODE_MUTE    = 2'd0;
  localparam logic [1:0] MODE_RUNNING = 2'd1;
  localparam logic [1:0] MODE_ALARM   = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;  // unused code, ignored

  // pattern timing in ms
  localparam logic [10:0] SOUND_MS          = 11'd100;
  localparam logic [10:0] RUNNING_PERIOD_MS = 11'd1000;
  localparam logic [10:0] ALARM_PERIOD_MS   = 11'd200;

  // tick interval register
  localparam int unsigned TICK_W = 10;
  localparam logic [TICK_W-1:0] TICK_RESET = 10'd50;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  new_mode;
    logic [15:0] beep_duration_ms;
  } in_beat_t;

  typedef struct packed {
    logic       buzzer_on;
    logic [1:0] current_mode;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]  background_mode;
    logic [10:0] pattern_elapsed;
    logic [15:0] beep_remaining;
    logic        drive_level;
  } state_t;

endpackage

/* rtl/bps_step.sv */
// ----------------------------------------------------------------------------
// bps_step
// Next-state logic for one beat: tick, mode change or one-shot beep.
// ----------------------------------------------------------------------------
module bps_step import bps_pkg::*; (
  input  state_t              state,
  input  in_beat_t            beat,
  input  logic [TICK_W-1:0]   tick_ms,
  output state_t              state_nxt,
  output out_beat_t           result
);

  logic [11:0] sum;
  logic [10:0] elapsed_add;
  logic [10:0] period;
  logic [15:0] tick_wide;

  // pattern timer advance, wrapped to 11 bits
  assign sum         = {1'b0, state.pattern_elapsed} + {2'b00, tick_ms};
  assign elapsed_add = sum[10:0];
  assign period      = (state.background_mode == MODE_RUNNING) ? RUNNING_PERIOD_MS
                                                               : ALARM_PERIOD_MS;
  assign tick_wide   = {{(16-TICK_W){1'b0}}, tick_ms};

  always_comb begin
    state_nxt = state;
    case (beat.op)
      OP_TICK: begin
        if (state.beep_remaining != 16'd0) begin
          // one-shot owns the output; pattern frozen
          if (state.beep_remaining > tick_wide) begin
            state_nxt.beep_remaining = state.beep_remaining - tick_wide;
          end else begin
            state_nxt.beep_remaining = 16'd0;
            if (state.background_mode == MODE_MUTE) begin
              state_nxt.drive_level = 1'b0;
            end
          end
        end else begin
          case (state.background_mode)
            MODE_MUTE: begin
              state_nxt.drive_level = 1'b0;
            end
            MODE_RUNNING, MODE_ALARM: begin
              if (elapsed_add < SOUND_MS) begin
                state_nxt.pattern_elapsed = elapsed_add;
                state_nxt.drive_level     = 1'b1;
              end else if (elapsed_add < period) begin
                state_nxt.pattern_elapsed = elapsed_add;
                state_nxt.drive_level     = 1'b0;
              end else begin
                state_nxt.pattern_elapsed = 11'd0;
                state_nxt.drive_level     = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      OP_SET_MODE: begin
        // unused mode code and a repeat of the held mode are ignored
        if (beat.new_mode != MODE_SPARE && beat.new_mode != state.background_mode) begin
          state_nxt.background_mode = beat.new_mode;
          state_nxt.pattern_elapsed = 11'd0;
          if (beat.new_mode == MODE_MUTE && state.beep_remaining == 16'd0) begin
            state_nxt.drive_level = 1'b0;
          end
        end
      end
      OP_BEEP: begin
        state_nxt.beep_remaining = beat.beep_duration_ms;
        state_nxt.drive_level    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign result.buzzer_on    = state_nxt.drive_level;
  assign result.current_mode = state_nxt.background_mode;

endmodule

/* rtl/bps_out_buf.sv */
// ----------------------------------------------------------------------------
// bps_out_buf
// Two-entry result buffer: output register plus skid stage, so a new beat
// is taken while a finished result waits on a stalled receiver.
// ----------------------------------------------------------------------------
module bps_out_buf import bps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_beat_t push_beat,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_beat_t out_data_r, out_data_nxt;
  out_beat_t skid_data_r, skid_data_nxt;
  logic      pop;

  assign pop = out_valid_r & ~out_stall;

  // fill and drain, skid entry always drains first
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_beat;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_beat;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_beat  = out_data_r;

endmodule

/* rtl/buzzer_pattern_sequencer_core.sv */
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer_core
// Buzzer drive sequencer: tick, mode change and one-shot beep beats in,
// drive level and mode out, one result per beat.
// ----------------------------------------------------------------------------
// The state update is a single compare-and-add pass done at the accepting
// edge, and the result lands in the output register, or in the skid entry
// while that register is held, on that same edge, so beats may arrive every
// cycle while in_stall is low. A two-entry output buffer (output register
// plus skid) decouples the sides; in_stall rises only when both entries hold
// results the receiver has not taken. tick_interval_ms (reset 50) is to be
// written through cfg_wr_en/cfg_wr_data while the block is idle; the block itself does not enforce this.
module buzzer_pattern_sequencer_core import bps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_beat_t          in_beat,
  output logic              out_valid,
  input  logic              out_stall,
  output out_beat_t         out_beat,
  input  logic              cfg_wr_en,
  input  logic [TICK_W-1:0] cfg_wr_data
);

  logic [TICK_W-1:0] tick_ms_r;
  state_t            state_r;
  state_t            state_nxt;
  out_beat_t         result;
  logic              accept;
  logic              buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid & ~buf_full;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_ms_r <= TICK_RESET;
    end else if (cfg_wr_en) begin
      tick_ms_r <= cfg_wr_data;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  bps_step u_step (
    .state     (state_r),
    .beat      (in_beat),
    .tick_ms   (tick_ms_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  bps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_beat (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

/* rtl/bps_checker.sv */
// ----------------------------------------------------------------------------
// bps_checker
// Port-level checks of the buzzer pattern sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module bps_checker import bps_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input in_beat_t          in_beat,
  input logic              out_valid,
  input logic              out_stall,
  input out_beat_t         out_beat
);

  // result held while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("result changed under stall");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // reported mode is always a defined one
  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_beat.current_mode != MODE_SPARE)
    else $error("undefined mode reported");

  // a beep into an empty output sounds on the next cycle
  a_beep_sounds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_beat.op == OP_BEEP && !out_valid
      |=> out_valid && out_beat.buzzer_on)
    else $error("one-shot beep did not sound");

endmodule

bind buzzer_pattern_sequencer_core bps_checker u_bps_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_beat     (in_beat),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_beat    (out_beat)
);
